[hdl/vgu_pkg.sv]
// ----------------------------------------------------------------------------
// vgu_pkg: shared types and constants of the voxel grid upsampler
// Field widths, multiply-accumulate operand widths, register codes and the
// configuration bundle passed from the register file to the sequencer.
// ----------------------------------------------------------------------------
package vgu_pkg;

	// grid and index sizing
	localparam int COORD_BITS   = 16;
	localparam int MAX_RATIO    = 4;
	localparam int INDEX_BITS   = 30;

	// fixed field widths of the ports
	localparam int REG_BITS        = 48;
	localparam int APB_DATA_BITS   = 64;
	localparam int APB_ADDR_BITS   = 6;
	localparam int REG_IDX_BITS    = APB_ADDR_BITS - 3;
	localparam int DENSITY_BITS    = 32;
	localparam int FINE_INDEX_BITS = 30;
	localparam int COUNT_BITS      = 30;

	// derived widths
	localparam int RATIO_BITS   = $clog2(MAX_RATIO + 1);
	localparam int MUL_A_BITS   = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;
	localparam int MUL_B_BITS   = COORD_BITS + 3;
	localparam int ACC_RAW_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int ACC_BITS     = (ACC_RAW_BITS > 64) ? 64 : ACC_RAW_BITS;

	typedef logic [COORD_BITS-1:0]          coord_t;
	typedef coord_t [2:0]                   vec3_t;
	typedef logic [RATIO_BITS-1:0]          ratio_t;
	typedef logic signed [ACC_BITS-1:0]     acc_t;
	typedef logic signed [DENSITY_BITS-1:0] density_t;
	typedef logic [INDEX_BITS-1:0]          index_t;
	typedef logic [COUNT_BITS-1:0]          count_t;

	// register map, one 64-bit slot per register
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_CSIZE = 3'd0,
		REG_FSIZE = 3'd1,
		REG_CORG  = 3'd2,
		REG_FORG  = 3'd3,
		REG_CDIM  = 3'd4,
		REG_FDIM  = 3'd5
	} reg_idx_t;

	localparam logic [REG_BITS-1:0] REG_RESET_ONES = 48'h0001_0001_0001;
	localparam count_t              COUNT_MAX      = '1;
	localparam density_t            EMPTY_DENSITY  = density_t'(32'h8000_0000);

	// configuration as seen by the sequencer, x in element 0
	typedef struct packed {
		vec3_t        csize;
		vec3_t        fsize;
		vec3_t        corg;
		vec3_t        forg;
		vec3_t        cdim;
		vec3_t        fdim;
		ratio_t [2:0] ratio;
	} cfg_t;

	// one operation of the shared multiply-accumulate unit
	typedef struct packed {
		logic                  acc;
		logic                  sub;
		logic [MUL_A_BITS-1:0] mul_a;
		logic [MUL_B_BITS-1:0] mul_b;
		acc_t                  addend;
	} mac_op_t;

endpackage

[hdl/vgu_regs.sv]
// ----------------------------------------------------------------------------
// vgu_regs: configuration register file
// APB-style write and read of the six 48-bit grid registers, field split
// and per-axis ratio of coarse to fine voxel size.
// ----------------------------------------------------------------------------
module vgu_regs import vgu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	localparam int RM_BITS = COORD_BITS + 3;

	logic [REG_BITS-1:0] csize_q, fsize_q, corg_q, forg_q, cdim_q, fdim_q;
	reg_idx_t            idx;
	logic                wr_en;

	// split a register into its three coordinate fields
	function automatic vec3_t split(logic [REG_BITS-1:0] r);
		logic [63:0] w;
		vec3_t       v;
		w = 64'(r);
		for (int f = 0; f < 3; f++) begin
			v[f] = COORD_BITS'(w >> (COORD_BITS * f));
		end
		return v;
	endfunction

	// truncated quotient clamped to the largest ratio, found by compares
	function automatic ratio_t calc_ratio(coord_t c, coord_t d);
		ratio_t               r;
		logic [RM_BITS-1:0]   m;
		r = '0;
		m = '0;
		if (d == '0) begin
			r = RATIO_BITS'(MAX_RATIO);
		end else begin
			for (int k = 1; k <= MAX_RATIO; k++) begin
				m = RM_BITS'(d) * RM_BITS'(k);
				if (RM_BITS'(c) >= m) r = RATIO_BITS'(k);
			end
		end
		return r;
	endfunction

	assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q <= REG_RESET_ONES;
			fsize_q <= REG_RESET_ONES;
			corg_q  <= '0;
			forg_q  <= '0;
			cdim_q  <= REG_RESET_ONES;
			fdim_q  <= REG_RESET_ONES;
		end else if (wr_en) begin
			unique case (idx)
				REG_CSIZE: csize_q <= pwdata[REG_BITS-1:0];
				REG_FSIZE: fsize_q <= pwdata[REG_BITS-1:0];
				REG_CORG:  corg_q  <= pwdata[REG_BITS-1:0];
				REG_FORG:  forg_q  <= pwdata[REG_BITS-1:0];
				REG_CDIM:  cdim_q  <= pwdata[REG_BITS-1:0];
				REG_FDIM:  fdim_q  <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (idx)
			REG_CSIZE: prdata = APB_DATA_BITS'(csize_q);
			REG_FSIZE: prdata = APB_DATA_BITS'(fsize_q);
			REG_CORG:  prdata = APB_DATA_BITS'(corg_q);
			REG_FORG:  prdata = APB_DATA_BITS'(forg_q);
			REG_CDIM:  prdata = APB_DATA_BITS'(cdim_q);
			REG_FDIM:  prdata = APB_DATA_BITS'(fdim_q);
			default:   prdata = '0;
		endcase
	end

	// configuration bundle
	always_comb begin
		cfg.csize = split(csize_q);
		cfg.fsize = split(fsize_q);
		cfg.corg  = split(corg_q);
		cfg.forg  = split(forg_q);
		cfg.cdim  = split(cdim_q);
		cfg.fdim  = split(fdim_q);
		for (int f = 0; f < 3; f++) begin
			cfg.ratio[f] = calc_ratio(cfg.csize[f], cfg.fsize[f]);
		end
	end

endmodule

[hdl/vgu_mac.sv]
// ----------------------------------------------------------------------------
// vgu_mac: shared multiply-accumulate unit
// Registered addend +/- a*b, with the previous result as addend on request.
// ----------------------------------------------------------------------------
module vgu_mac import vgu_pkg::*; (
	input  logic    clk,
	input  mac_op_t op,
	output acc_t    res
);

	logic [ACC_RAW_BITS-1:0] prod_full;
	acc_t                    prod;
	acc_t                    base;
	acc_t                    sum;
	acc_t                    res_s1;

	// product, then add or subtract onto the chosen base
	assign prod_full = op.mul_a * op.mul_b;
	assign prod      = acc_t'(prod_full);
	assign base      = op.acc ? res_s1 : op.addend;
	assign sum       = op.sub ? (base - prod) : (base + prod);

	always_ff @(posedge clk) begin
		res_s1 <= sum;
	end

	assign res = res_s1;

endmodule

[hdl/vgu_seq.sv]
// ----------------------------------------------------------------------------
// vgu_seq: item sequencer
// Position counters, setup of block offsets on the shared multiply-accumulate
// unit, the sub-voxel walk with overlap test and index stepping, and the
// output register.
// ----------------------------------------------------------------------------
module vgu_seq import vgu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  density_t                   density,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [FINE_INDEX_BITS-1:0] fine_index,
	output density_t                   value,
	output logic                       write,
	output count_t                     filled_count,
	output logic                       last,
	output mac_op_t                    mac_op,
	input  acc_t                       mac_res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		STP_BX,
		STP_BY,
		STP_BZ,
		STP_FXY,
		STP_OX0,
		STP_OX1,
		STP_OY0,
		STP_OY1,
		STP_OZ0,
		STP_OZ1,
		STP_IX0,
		STP_IX1,
		STP_CAP
	} step_t;

	state_t st_q;
	step_t  step_q;

	// position and running count
	coord_t pos_x_q, pos_y_q, pos_z_q;
	count_t written_total_q;

	// item snapshot
	coord_t   ipx_q, ipy_q, ipz_q;
	ratio_t   nx_q, ny_q, nz_q;
	density_t dens_q;

	// setup results
	logic [MUL_B_BITS-1:0] bx_q, by_q, bz_q;
	index_t                fdxy_q;
	acc_t                  ox_q, oy_q, oz_q;

	// walk state
	ratio_t a_q, b_q, c_q;
	acc_t   tx_q, ty_q, tz_q;
	index_t idx_q, row_q, plane_q;

	// output register
	logic                       out_valid_q;
	logic [FINE_INDEX_BITS-1:0] out_index_q;
	density_t                   out_value_q;
	logic                       out_write_q;
	count_t                     out_filled_q;
	logic                       out_last_q;

	logic   in_fire, item_live, out_take, emit_fire;
	logic   x_wrap, y_wrap, z_wrap;
	coord_t pos_x_nx, pos_y_nx, pos_z_nx;
	logic   ov_x, ov_y, ov_z, w;
	logic   last_sub;
	count_t cnt_next;
	ratio_t a_inc, b_inc, c_inc;
	index_t row_step, plane_step;

	// box overlap on one axis: -fs < t < cs
	function automatic logic overlap(acc_t t, coord_t cs, coord_t fs);
		acc_t cs_e;
		acc_t tf;
		cs_e = acc_t'(cs);
		tf   = t + acc_t'(fs);
		return (t < cs_e) && (tf > acc_t'(0));
	endfunction

	function automatic acc_t org_diff(coord_t f, coord_t c);
		return acc_t'($signed(f)) - acc_t'($signed(c));
	endfunction

	assign in_ready  = (st_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign item_live = (density != EMPTY_DENSITY) && (cfg.ratio[0] != '0)
		&& (cfg.ratio[1] != '0) && (cfg.ratio[2] != '0);
	assign out_take  = out_valid_q && out_ready;
	assign emit_fire = (st_q == ST_EMIT) && (!out_valid_q || out_ready);

	// raster position advance, a zero dimension pins its counter
	always_comb begin
		x_wrap   = !(({1'b0, pos_x_q} + 1'b1) < {1'b0, cfg.cdim[0]});
		y_wrap   = !(({1'b0, pos_y_q} + 1'b1) < {1'b0, cfg.cdim[1]});
		z_wrap   = !(({1'b0, pos_z_q} + 1'b1) < {1'b0, cfg.cdim[2]});
		pos_x_nx = x_wrap ? '0 : pos_x_q + 1'b1;
		pos_y_nx = pos_y_q;
		pos_z_nx = pos_z_q;
		if (x_wrap) begin
			pos_y_nx = y_wrap ? '0 : pos_y_q + 1'b1;
			if (y_wrap) begin
				pos_z_nx = z_wrap ? '0 : pos_z_q + 1'b1;
			end
		end
	end

	// operand selection for the shared unit
	always_comb begin
		mac_op = '0;
		unique case (step_q)
			STP_BX: begin
				mac_op.mul_a = MUL_A_BITS'(ipx_q);
				mac_op.mul_b = MUL_B_BITS'(nx_q);
			end
			STP_BY: begin
				mac_op.mul_a = MUL_A_BITS'(ipy_q);
				mac_op.mul_b = MUL_B_BITS'(ny_q);
			end
			STP_BZ: begin
				mac_op.mul_a = MUL_A_BITS'(ipz_q);
				mac_op.mul_b = MUL_B_BITS'(nz_q);
			end
			STP_FXY: begin
				mac_op.mul_a = MUL_A_BITS'(cfg.fdim[0]);
				mac_op.mul_b = MUL_B_BITS'(cfg.fdim[1]);
			end
			STP_OX0: begin
				mac_op.mul_a  = MUL_A_BITS'(cfg.fsize[0]);
				mac_op.mul_b  = bx_q;
				mac_op.addend = org_diff(cfg.forg[0], cfg.corg[0]);
			end
			STP_OX1: begin
				mac_op.mul_a = MUL_A_BITS'(cfg.csize[0]);
				mac_op.mul_b = MUL_B_BITS'(ipx_q);
				mac_op.sub   = 1'b1;
				mac_op.acc   = 1'b1;
			end
			STP_OY0: begin
				mac_op.mul_a  = MUL_A_BITS'(cfg.fsize[1]);
				mac_op.mul_b  = by_q;
				mac_op.addend = org_diff(cfg.forg[1], cfg.corg[1]);
			end
			STP_OY1: begin
				mac_op.mul_a = MUL_A_BITS'(cfg.csize[1]);
				mac_op.mul_b = MUL_B_BITS'(ipy_q);
				mac_op.sub   = 1'b1;
				mac_op.acc   = 1'b1;
			end
			STP_OZ0: begin
				mac_op.mul_a  = MUL_A_BITS'(cfg.fsize[2]);
				mac_op.mul_b  = bz_q;
				mac_op.addend = org_diff(cfg.forg[2], cfg.corg[2]);
			end
			STP_OZ1: begin
				mac_op.mul_a = MUL_A_BITS'(cfg.csize[2]);
				mac_op.mul_b = MUL_B_BITS'(ipz_q);
				mac_op.sub   = 1'b1;
				mac_op.acc   = 1'b1;
			end
			STP_IX0: begin
				mac_op.mul_a  = MUL_A_BITS'(cfg.fdim[0]);
				mac_op.mul_b  = by_q;
				mac_op.addend = acc_t'(bx_q);
			end
			STP_IX1: begin
				mac_op.mul_a = MUL_A_BITS'(fdxy_q);
				mac_op.mul_b = bz_q;
				mac_op.acc   = 1'b1;
			end
			STP_CAP: ;
			default: ;
		endcase
	end

	// current sub-voxel: overlap, count and index steps
	always_comb begin
		ov_x       = overlap(tx_q, cfg.csize[0], cfg.fsize[0]);
		ov_y       = overlap(ty_q, cfg.csize[1], cfg.fsize[1]);
		ov_z       = overlap(tz_q, cfg.csize[2], cfg.fsize[2]);
		w          = ov_x && ov_y && ov_z;
		a_inc      = RATIO_BITS'(a_q + 1'b1);
		b_inc      = RATIO_BITS'(b_q + 1'b1);
		c_inc      = RATIO_BITS'(c_q + 1'b1);
		last_sub   = (a_inc == nx_q) && (b_inc == ny_q) && (c_inc == nz_q);
		cnt_next   = (w && (written_total_q != COUNT_MAX)) ? written_total_q + 1'b1
			: written_total_q;
		row_step   = row_q + INDEX_BITS'(cfg.fdim[0]);
		plane_step = plane_q + fdxy_q;
	end

	// sequencer, walk and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ST_IDLE;
			step_q          <= STP_BX;
			pos_x_q         <= '0;
			pos_y_q         <= '0;
			pos_z_q         <= '0;
			written_total_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_take && !emit_fire) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						pos_x_q <= pos_x_nx;
						pos_y_q <= pos_y_nx;
						pos_z_q <= pos_z_nx;
						ipx_q   <= pos_x_q;
						ipy_q   <= pos_y_q;
						ipz_q   <= pos_z_q;
						nx_q    <= cfg.ratio[0];
						ny_q    <= cfg.ratio[1];
						nz_q    <= cfg.ratio[2];
						dens_q  <= density;
						if (item_live) begin
							st_q   <= ST_SETUP;
							step_q <= STP_BX;
						end
					end
				end
				ST_SETUP: begin
					if (step_q != STP_CAP) step_q <= step_t'(step_q + 4'd1);
					// the unit's output holds the previous step's result
					unique case (step_q)
						STP_BY:  bx_q   <= MUL_B_BITS'(mac_res);
						STP_BZ:  by_q   <= MUL_B_BITS'(mac_res);
						STP_FXY: bz_q   <= MUL_B_BITS'(mac_res);
						STP_OX0: fdxy_q <= INDEX_BITS'(mac_res);
						STP_OY0: ox_q   <= mac_res;
						STP_OZ0: oy_q   <= mac_res;
						STP_IX0: oz_q   <= mac_res;
						STP_CAP: begin
							idx_q   <= INDEX_BITS'(mac_res);
							row_q   <= INDEX_BITS'(mac_res);
							plane_q <= INDEX_BITS'(mac_res);
							tx_q    <= ox_q;
							ty_q    <= oy_q;
							tz_q    <= oz_q;
							a_q     <= '0;
							b_q     <= '0;
							c_q     <= '0;
							step_q  <= STP_BX;
							st_q    <= ST_EMIT;
						end
						default: ;
					endcase
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid_q     <= 1'b1;
						out_index_q     <= FINE_INDEX_BITS'(idx_q);
						out_value_q     <= dens_q;
						out_write_q     <= w;
						out_filled_q    <= cnt_next;
						out_last_q      <= last_sub;
						written_total_q <= cnt_next;
						// x inner, y middle, z outer
						if (a_inc != nx_q) begin
							a_q   <= a_inc;
							tx_q  <= tx_q + acc_t'(cfg.fsize[0]);
							idx_q <= idx_q + 1'b1;
						end else begin
							a_q  <= '0;
							tx_q <= ox_q;
							if (b_inc != ny_q) begin
								b_q   <= b_inc;
								ty_q  <= ty_q + acc_t'(cfg.fsize[1]);
								row_q <= row_step;
								idx_q <= row_step;
							end else begin
								b_q  <= '0;
								ty_q <= oy_q;
								if (c_inc != nz_q) begin
									c_q     <= c_inc;
									tz_q    <= tz_q + acc_t'(cfg.fsize[2]);
									plane_q <= plane_step;
									row_q   <= plane_step;
									idx_q   <= plane_step;
								end else begin
									st_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign fine_index   = out_index_q;
	assign value        = out_value_q;
	assign write        = out_write_q;
	assign filled_count = out_filled_q;
	assign last         = out_last_q;

	// walk counters stay inside the block
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> ((a_q < nx_q) && (b_q < ny_q) && (c_q < nz_q)))
		else $error("sub-voxel counter beyond ratio");

	// no walk for a zero ratio
	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> ((nx_q != '0) && (ny_q != '0) && (nz_q != '0)))
		else $error("walk started with a zero ratio");

	// final sub-voxel ends the item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && last_sub) |=> (st_q == ST_IDLE))
		else $error("sequencer busy after final sub-voxel");

	// setup always precedes the walk
	a_setup_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (st_q != ST_EMIT))
		else $error("walk entered without setup");

	// a written result is always counted
	a_count_written: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_write_q) |-> (out_filled_q != '0))
		else $error("written result with zero filled count");

endmodule

[hdl/voxel_grid_upsample.sv]
// ----------------------------------------------------------------------------
// voxel_grid_upsample: nearest-neighbour upsampling of a coarse voxel grid
// Coarse densities enter in raster order; each non-empty voxel yields one
// result per fine sub-voxel with index, density, overlap flag, running
// written count and a last marker.
// ----------------------------------------------------------------------------
// An empty voxel (the minimum density) or a zero ratio on any axis is taken
// without a setup and gives no results, but still advances the x, y, z position.
// Any other voxel runs a setup on one shared multiply-accumulate unit (block
// base per axis, fine row-plane stride, box offsets per axis and the base
// index), then walks its nx*ny*nz sub-voxels at one result per cycle while the
// output is not stalled. The next voxel is taken as soon as the final result
// sits in the output register. Per-axis ratios follow the configuration
// registers combinationally and are sampled when a voxel is taken, so a write
// to them takes effect from the next voxel taken.
module voxel_grid_upsample import vgu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_ADDR_BITS-1:0]   paddr,
	input  logic [APB_DATA_BITS-1:0]   pwdata,
	output logic [APB_DATA_BITS-1:0]   prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  density_t                   density,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [FINE_INDEX_BITS-1:0] fine_index,
	output density_t                   value,
	output logic                       write,
	output count_t                     filled_count,
	output logic                       last
);

	cfg_t    cfg;
	mac_op_t mac_op;
	acc_t    mac_res;

	// configuration registers
	vgu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shared arithmetic unit
	vgu_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.res (mac_res)
	);

	// sequencer and output register
	vgu_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.density      (density),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fine_index   (fine_index),
		.value        (value),
		.write        (write),
		.filled_count (filled_count),
		.last         (last),
		.mac_op       (mac_op),
		.mac_res      (mac_res)
	);

endmodule
